// ===== design/single_source_shortest_path_defines.svh =====
// assertion macros shared by the shortest path checker
`ifndef SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SSSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sssp assertion failed");

// consequent must hold in the cycle after the antecedent
`define SSSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sssp assertion failed");

`endif

// ===== design/sssp_pkg.sv =====
// shared types, constants and helpers for the shortest path block
`default_nettype none

package sssp_pkg;

    localparam int MAX_NODES  = 16;
    localparam int NODE_LIMIT = (MAX_NODES < 16) ? MAX_NODES : 16;
    localparam int MAT_DEPTH  = MAX_NODES * MAX_NODES;
    localparam int MAT_AW     = $clog2(MAT_DEPTH);

    localparam int NODE_W     = 4;
    localparam int DIST_W     = 24;
    localparam int WEIGHT_W   = 16;
    localparam int CNT_W      = 5;
    localparam int DIST_DEPTH = 16;

    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [DIST_W-1:0]   dist_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [MAT_AW-1:0]   mat_addr_t;

    localparam cnt_t NODE_COUNT_RESET = CNT_W'(16);

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef struct packed {
        logic    kind;
        node_t   edge_from;
        node_t   edge_to;
        weight_t edge_weight;
        node_t   source_node;
    } item_t;

    typedef struct packed {
        node_t node;
        dist_t distance;
        logic  reachable;
        logic  last;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEED,
        ST_SCAN,
        ST_PICK,
        ST_RELAX,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic      clr_we;
        mat_addr_t clr_addr;
        logic      edge_we;
        logic      rd_en;
        logic      row_pick;
        node_t     src;
        node_t     col;
        node_t     idx;
        logic      seed_en;
        logic      seed_self;
        logic      scan_en;
        logic      scan_first;
        logic      pick_take;
        logic      relax_en;
        logic      emit_load;
        logic      emit_last;
    } cmd_t;

    typedef struct packed {
        logic have;
        logic slot_free;
    } status_t;

    function automatic mat_addr_t mat_addr(node_t row, node_t col);
        return MAT_AW'(row) * MAT_AW'(MAX_NODES) + MAT_AW'(col);
    endfunction

endpackage

`default_nettype wire

// ===== design/sssp_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module sssp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/sssp_ctrl.sv =====
// controller: sequencing of clear, seed, scan, pick, relax and emit phases
`default_nettype none

module sssp_ctrl
    import sssp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    input  wire logic    cfg_we,
    input  wire cnt_t    cfg_wdata,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t    state_reg, state_next;
    cnt_t      cnt_reg, cnt_next;
    mat_addr_t clr_reg, clr_next;
    logic      vld_d_reg, vld_d_next;
    node_t     col_d_reg, col_d_next;
    node_t     src_reg, src_next;
    cnt_t      node_count_reg, node_count_next;

    cnt_t n_eff;
    cnt_t n_last;
    logic accept;
    logic run_start;
    logic issue;
    logic data_last;
    logic emit_skip;
    logic advance;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (node_count_reg > CNT_W'(NODE_LIMIT))
        begin
            n_eff = CNT_W'(NODE_LIMIT);
        end
        else
        begin
            n_eff = node_count_reg;
        end
    end

    assign n_last     = n_eff - CNT_W'(1);
    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign run_start  = accept && (item.kind == KIND_RUN)
                        && (CNT_W'(item.source_node) < n_eff);
    assign issue      = (cnt_reg < n_eff);
    assign data_last  = vld_d_reg && (CNT_W'(col_d_reg) == n_last);
    assign emit_skip  = (cnt_reg[NODE_W-1:0] == src_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_CLEAR:
            begin
                if (clr_reg == MAT_AW'(MAT_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (run_start)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED, ST_RELAX:
            begin
                if (data_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == n_last)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                state_next = status.have ? ST_RELAX : ST_EMIT;
            end
            ST_EMIT:
            begin
                if ((cnt_reg == n_last) && (emit_skip || status.slot_free))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd          = '0;
        cmd.src      = src_reg;
        cmd.col      = cnt_reg[NODE_W-1:0];
        cmd.idx      = cnt_reg[NODE_W-1:0];
        cmd.clr_addr = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_we = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.edge_we = accept && (item.kind == KIND_EDGE);
            end
            ST_SEED:
            begin
                cmd.rd_en     = issue;
                cmd.seed_en   = vld_d_reg;
                cmd.seed_self = (col_d_reg == src_reg);
                cmd.idx       = col_d_reg;
            end
            ST_SCAN:
            begin
                cmd.scan_en    = 1'b1;
                cmd.scan_first = (cnt_reg == '0);
            end
            ST_PICK:
            begin
                cmd.pick_take = status.have;
            end
            ST_RELAX:
            begin
                cmd.rd_en    = issue;
                cmd.row_pick = 1'b1;
                // the source distance is never updated
                cmd.relax_en = vld_d_reg && (col_d_reg != src_reg);
                cmd.idx      = col_d_reg;
            end
            ST_EMIT:
            begin
                cmd.emit_load = !emit_skip && status.slot_free;
                cmd.emit_last = (cnt_reg == n_last)
                                || ((CNT_W'(src_reg) == n_last)
                                    && (cnt_reg == n_eff - CNT_W'(2)));
            end
            default:
            begin
                cmd.clr_we = 1'b0;
            end
        endcase
    end

    // counters and captured values
    always_comb
    begin
        unique case (state_reg) inside
            ST_SEED, ST_RELAX: advance = issue;
            ST_SCAN:           advance = 1'b1;
            ST_EMIT:           advance = emit_skip || status.slot_free;
            default:           advance = 1'b0;
        endcase

        if (state_next != state_reg)
        begin
            cnt_next = '0;
        end
        else if (advance)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end

        clr_next        = (state_reg == ST_CLEAR) ? clr_reg + MAT_AW'(1) : clr_reg;
        vld_d_next      = cmd.rd_en;
        col_d_next      = cnt_reg[NODE_W-1:0];
        src_next        = accept ? item.source_node : src_reg;
        node_count_next = cfg_we ? cfg_wdata : node_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            clr_reg        <= '0;
            vld_d_reg      <= 1'b0;
            node_count_reg <= NODE_COUNT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            clr_reg        <= clr_next;
            vld_d_reg      <= vld_d_next;
            node_count_reg <= node_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_d_reg <= col_d_next;
        src_reg   <= src_next;
    end

endmodule

`default_nettype wire

// ===== design/sssp_dp.sv =====
// datapath: weight matrix, distance table, minimum search and result register
`default_nettype none

module sssp_dp
    import sssp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire item_t   item,
    input  wire cmd_t    cmd,
    output status_t      status,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    dist_t                 dist_reg [DIST_DEPTH];
    dist_t                 dist_next [DIST_DEPTH];
    logic [DIST_DEPTH-1:0] found_reg, found_next;
    dist_t                 best_reg, best_next;
    node_t                 pick_reg, pick_next;
    logic                  have_reg, have_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;

    logic                  edge_ok;
    logic                  mem_we;
    mat_addr_t             mem_waddr;
    weight_t               mem_wdata;
    mat_addr_t             mem_raddr;
    weight_t               mem_rdata;
    node_t                 row;
    dist_t                 cur_dist;
    logic                  cur_found;
    logic [DIST_W:0]       cand;
    dist_t                 scan_best;
    logic                  scan_have;
    logic                  take;
    logic                  slot_free;

    // edges outside the usable matrix are dropped
    assign edge_ok   = (CNT_W'(item.edge_from) < CNT_W'(NODE_LIMIT))
                       && (CNT_W'(item.edge_to) < CNT_W'(NODE_LIMIT));
    assign mem_we    = cmd.clr_we || (cmd.edge_we && edge_ok);
    assign mem_waddr = cmd.clr_we ? cmd.clr_addr : mat_addr(item.edge_from, item.edge_to);
    assign mem_wdata = cmd.clr_we ? '0 : item.edge_weight;
    assign row       = cmd.row_pick ? pick_reg : cmd.src;
    assign mem_raddr = mat_addr(row, cmd.col);

    sssp_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAT_DEPTH)
    ) u_mat (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (cmd.rd_en),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cur_dist  = dist_reg[cmd.idx];
    assign cur_found = found_reg[cmd.idx];
    // best_reg holds the picked node's distance during relaxation
    assign cand      = {1'b0, best_reg} + (DIST_W + 1)'(mem_rdata);
    assign scan_best = cmd.scan_first ? '1 : best_reg;
    assign scan_have = cmd.scan_first ? 1'b0 : have_reg;
    // ties go to the later index
    assign take      = !cur_found && (cur_dist != '0) && (cur_dist <= scan_best);
    assign slot_free = !out_valid_reg || result_ready;

    always_comb
    begin
        dist_next      = dist_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        have_next      = have_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (cmd.seed_en)
        begin
            dist_next[cmd.idx]  = DIST_W'(mem_rdata);
            found_next[cmd.idx] = cmd.seed_self;
        end

        if (cmd.relax_en && (mem_rdata != '0)
            && ((cur_dist == '0) || (cand < {1'b0, cur_dist})))
        begin
            dist_next[cmd.idx] = cand[DIST_W-1:0];
        end

        if (cmd.scan_en)
        begin
            best_next = take ? cur_dist : scan_best;
            pick_next = take ? cmd.idx : pick_reg;
            have_next = take || scan_have;
        end

        if (cmd.pick_take)
        begin
            found_next[pick_reg] = 1'b1;
        end

        if (cmd.emit_load)
        begin
            out_next.node      = cmd.idx;
            out_next.distance  = cur_dist;
            out_next.reachable = (cur_dist != '0);
            out_next.last      = cmd.emit_last;
            out_valid_next     = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg  <= dist_next;
        found_reg <= found_next;
        best_reg  <= best_next;
        pick_reg  <= pick_next;
        out_reg   <= out_next;
    end

    assign status.have      = have_reg;
    assign status.slot_free = slot_free;
    assign result_valid     = out_valid_reg;
    assign result           = out_reg;

endmodule

`default_nettype wire

// ===== design/single_source_shortest_path.sv =====
// top level of the single source shortest path block
// edge transaction: accepted while idle, no result
// run transaction on n nodes: one matrix entry read per cycle in the seed and relax
// phases and one distance compare per cycle in the minimum scan
// results leave one per cycle through a single output register while result_ready is high;
// next item taken once idle; reset: asynchronous, active low; then the matrix is zeroed
`default_nettype none

module single_source_shortest_path
    import sssp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result,
    input  wire logic    cfg_we,
    input  wire cnt_t    cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    sssp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .status     (status),
        .cmd        (cmd)
    );

    sssp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== design/sssp_checker.sv =====
// port level checks for the shortest path block, bound to the top level
`default_nettype none
`include "single_source_shortest_path_defines.svh"

module sssp_checker
    import sssp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    input  wire logic    item_ready,
    input  wire item_t   item,
    input  wire logic    result_valid,
    input  wire logic    result_ready,
    input  wire result_t result,
    input  wire logic    cfg_we,
    input  wire cnt_t    cfg_wdata
);

    // a stalled result transaction holds
    `SSSP_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result))

    // reachable flag agrees with a nonzero distance
    `SSSP_ASSERT_NOW(a_reach_dist, clk, rst_n, result_valid, result.reachable == (result.distance != '0))

    // while a run still has results to give, no new item is taken
    `SSSP_ASSERT_NOW(a_busy_emit, clk, rst_n, result_valid && !result.last, !item_ready)

endmodule

bind single_source_shortest_path sssp_checker u_sssp_checker (.*);

`default_nettype wire
